@@ sv/gmrc_pkg.sv @@
// shared types and constants of the greedy mask rectangle cover block
// no dependencies; compiled first

package gmrc_pkg;

	// default store geometry
	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	// reset value of both size registers
	localparam int CFG_RESET = 256;

	// payload widths
	localparam int OP_W       = 2;
	localparam int ALPHA_W    = 8;
	localparam int COORD_W    = 8;
	localparam int SIZE_W     = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	// operation codes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_FETCH = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	// scan sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_SCAN_CHK,
		ST_WID,
		ST_WID_CHK,
		ST_HGT_ROW,
		ST_HGT,
		ST_HGT_CHK,
		ST_MERGE,
		ST_EMIT
	} seq_state_t;

endpackage

@@ sv/gmrc_req_if.sv @@
// request channel: operation code and alpha byte
// depends on gmrc_pkg

interface gmrc_req_if
	import gmrc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [ALPHA_W-1:0] alpha;

	modport source (output valid, output operation, output alpha, input ready);
	modport sink (input valid, input operation, input alpha, output ready);
endinterface

@@ sv/gmrc_rsp_if.sv @@
// response channel: one rectangle or a done flag per fetch
// depends on gmrc_pkg

interface gmrc_rsp_if
	import gmrc_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               found;
	logic [COORD_W-1:0] rect_x;
	logic [COORD_W-1:0] rect_y;
	logic [SIZE_W-1:0]  rect_width;
	logic [SIZE_W-1:0]  rect_height;

	modport source (
		output valid, output found, output rect_x, output rect_y,
		output rect_width, output rect_height, input ready
	);
	modport sink (
		input valid, input found, input rect_x, input rect_y,
		input rect_width, input rect_height, output ready
	);
endinterface

@@ sv/gmrc_cfg_if.sv @@
// configuration write channel: register index and write data
// depends on gmrc_pkg

interface gmrc_cfg_if
	import gmrc_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/gmrc_store.sv @@
// opacity and merged-mask memories, one shared read port, registered read
// depends on gmrc_pkg

module gmrc_store
	import gmrc_pkg::*;
#(
	parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic          rd_free,
	input  logic [AW-1:0] wr_addr,
	input  logic          opq_we,
	input  logic          opq_bit,
	input  logic          mrg_we,
	input  logic          mrg_bit
);

	logic opq_mem [DEPTH];
	logic mrg_mem [DEPTH];
	logic opq_rd_q;
	logic mrg_rd_q;

	always_ff @(posedge clk) begin
		if (opq_we) begin
			opq_mem[wr_addr] <= opq_bit;
		end
		if (rd_en) begin
			opq_rd_q <= opq_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (mrg_we) begin
			mrg_mem[wr_addr] <= mrg_bit;
		end
		if (rd_en) begin
			mrg_rd_q <= mrg_mem[rd_addr];
		end
	end

	// opaque and not yet covered
	assign rd_free = opq_rd_q & ~mrg_rd_q;

endmodule

@@ sv/greedy_mask_rectangle_cover_core.sv @@
// top level of the greedy mask rectangle cover block
// depends on gmrc_pkg, gmrc_req_if, gmrc_rsp_if, gmrc_cfg_if and gmrc_store
//
// usage: set image_width (index 0) and image_height (index 1) on cfg, then
// send one load item per pixel in raster order on req (alpha nonzero means
// opaque). each fetch item returns one item on rsp: the next rectangle of a
// greedy raster cover (found = 1), or found = 0 once the scan is finished.
// a clear item restarts the load address, the scan and the merged mask.
// loads stream back to back, one per cycle while req is ready. a clear, and reset
// itself, start a clearing pass over all MAX_WIDTH * MAX_HEIGHT entries of the
// merged mask (65536 by default), during which req is not ready.
// a fetch probes mask pixels through the single read port of the mask store,
// one registered read at a time, then marks the covered pixels in a merge
// write-back of one entry a cycle, after a setup step that finds the scan row.
// rsp is held in an output register: req stays ready for loads and clears
// while a result waits; a fetch that finishes while rsp is still stalled
// waits at the end until the register is free. cfg is always ready; it must be
// written only while no item is in flight, which the block itself does not enforce.

module greedy_mask_rectangle_cover_core
	import gmrc_pkg::*;
#(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gmrc_req_if.sink   req,
	gmrc_rsp_if.source rsp,
	gmrc_cfg_if.sink   cfg
);

	// coordinate and count widths
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (STORE > 1) ? $clog2(STORE) : 1;
	localparam int LW    = AW + 1;
	// size registers come out of reset clamped to the store
	localparam int RST_W = (CFG_RESET > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET;
	localparam int RST_H = (CFG_RESET > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET;
	localparam int RST_AREA = RST_W * RST_H;

	// sequencer and control state
	seq_state_t state_q, state_d;
	logic          clr_busy_q, clr_busy_d;
	logic [AW-1:0] clr_addr_q, clr_addr_d;
	logic [LW-1:0] load_addr_q, load_addr_d;
	logic [XW-1:0] cx_q, cx_d;
	logic [YW-1:0] cy_q, cy_d;
	logic          done_q, done_d;
	logic          out_valid_q, out_valid_d;

	// effective image size, kept clamped, and its area
	logic [WW-1:0] eff_w_q;
	logic [HW-1:0] eff_h_q;
	logic [LW-1:0] area_q;
	logic [WW-1:0] cfg_w;
	logic [HW-1:0] cfg_h;
	logic [LW-1:0] area_w_upd;
	logic [LW-1:0] area_h_upd;

	// rectangle working registers
	logic [LW-1:0] base_q, base_d;   // address of the scan row start
	logic [XW-1:0] x0_q, x0_d;
	logic [YW-1:0] y0_q, y0_d;
	logic [WW-1:0] rw_q, rw_d;
	logic [HW-1:0] rh_q, rh_d;
	logic [HW-1:0] hy_q, hy_d;       // row under test, then merge row count
	logic [LW-1:0] rb_q, rb_d;       // address of that row's start
	logic [WW-1:0] run_q, run_d;     // run length, then merge column
	logic          found_q, found_d;

	// output register
	logic               load_out;
	logic               rsp_found_q;
	logic [COORD_W-1:0] rsp_x_q;
	logic [COORD_W-1:0] rsp_y_q;
	logic [SIZE_W-1:0]  rsp_w_q;
	logic [SIZE_W-1:0]  rsp_h_q;

	// store access
	logic          rd_en;
	logic [LW-1:0] rd_addr;
	logic          rd_free;
	logic [AW-1:0] wr_addr;
	logic          opq_we;
	logic          opq_bit;
	logic          mrg_we;
	logic          mrg_bit;

	// address and step helpers
	logic          req_ready;
	logic          accept;
	logic [LW-1:0] scan_addr;
	logic [LW-1:0] wid_addr;
	logic [LW-1:0] hgt_addr;
	logic [WW-1:0] cx_inc;
	logic [HW-1:0] cy_inc;
	logic [WW-1:0] x_end;

	assign scan_addr = base_q + LW'(cx_q);
	assign wid_addr  = base_q + LW'(x0_q) + LW'(rw_q);
	assign hgt_addr  = rb_q + LW'(x0_q) + LW'(run_q);
	assign cx_inc    = WW'(cx_q) + WW'(1);
	assign cy_inc    = HW'(cy_q) + HW'(1);
	assign x_end     = WW'(cx_q) + rw_q;

	assign req_ready = (state_q == ST_IDLE) && !clr_busy_q;
	assign accept    = req.valid && req_ready;
	assign req.ready = req_ready;
	assign cfg.ready = 1'b1;

	// register writes: zero acts as one, anything above the store as its size
	always_comb begin
		if (cfg.data == '0) begin
			cfg_w = WW'(1);
		end else if (32'(cfg.data) > MAX_WIDTH) begin
			cfg_w = WW'(MAX_WIDTH);
		end else begin
			cfg_w = WW'(cfg.data);
		end
		if (cfg.data == '0) begin
			cfg_h = HW'(1);
		end else if (32'(cfg.data) > MAX_HEIGHT) begin
			cfg_h = HW'(MAX_HEIGHT);
		end else begin
			cfg_h = HW'(cfg.data);
		end
	end

	assign area_w_upd = LW'(cfg_w) * LW'(eff_h_q);
	assign area_h_upd = LW'(eff_w_q) * LW'(cfg_h);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q <= WW'(RST_W);
			eff_h_q <= HW'(RST_H);
			area_q  <= LW'(RST_AREA);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_WIDTH: begin
					eff_w_q <= cfg_w;
					area_q  <= area_w_upd;
				end
				REG_HEIGHT: begin
					eff_h_q <= cfg_h;
					area_q  <= area_h_upd;
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer: next state, store access and datapath updates
	always_comb begin
		state_d     = state_q;
		clr_busy_d  = clr_busy_q;
		clr_addr_d  = clr_addr_q;
		load_addr_d = load_addr_q;
		cx_d        = cx_q;
		cy_d        = cy_q;
		done_d      = done_q;
		base_d      = base_q;
		x0_d        = x0_q;
		y0_d        = y0_q;
		rw_d        = rw_q;
		rh_d        = rh_q;
		hy_d        = hy_q;
		rb_d        = rb_q;
		run_d       = run_q;
		found_d     = found_q;
		load_out    = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = scan_addr;
		wr_addr     = load_addr_q[AW-1:0];
		opq_we      = 1'b0;
		opq_bit     = |req.alpha;
		mrg_we      = 1'b0;
		mrg_bit     = 1'b0;

		// clearing pass over the merged mask, one entry a cycle
		if (clr_busy_q) begin
			mrg_we  = 1'b1;
			mrg_bit = 1'b0;
			wr_addr = clr_addr_q;
			if (clr_addr_q == AW'(STORE - 1)) begin
				clr_busy_d = 1'b0;
			end else begin
				clr_addr_d = clr_addr_q + AW'(1);
			end
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (req.operation)
						OP_LOAD: begin
							// loads past the end of the image are dropped
							if (load_addr_q < area_q) begin
								opq_we      = 1'b1;
								wr_addr     = load_addr_q[AW-1:0];
								load_addr_d = load_addr_q + LW'(1);
							end
						end
						OP_FETCH: begin
							state_d = ST_START;
						end
						OP_CLEAR: begin
							clr_busy_d  = 1'b1;
							clr_addr_d  = '0;
							load_addr_d = '0;
							cx_d        = '0;
							cy_d        = '0;
							done_d      = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end

			ST_START: begin
				if (done_q) begin
					found_d = 1'b0;
					state_d = ST_EMIT;
				end else if (HW'(cy_q) >= eff_h_q) begin
					// image shrank under the scan row
					done_d  = 1'b1;
					cy_d    = '0;
					cx_d    = '0;
					found_d = 1'b0;
					state_d = ST_EMIT;
				end else begin
					base_d  = LW'(cy_q) * LW'(eff_w_q);
					state_d = ST_SCAN;
				end
			end

			ST_SCAN: begin
				if (WW'(cx_q) >= eff_w_q) begin
					// column outside the image, wrap to the next row
					cx_d = '0;
					if (cy_inc >= eff_h_q) begin
						done_d  = 1'b1;
						cy_d    = '0;
						found_d = 1'b0;
						state_d = ST_EMIT;
					end else begin
						cy_d   = YW'(cy_inc);
						base_d = base_q + LW'(eff_w_q);
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = scan_addr;
					state_d = ST_SCAN_CHK;
				end
			end

			ST_SCAN_CHK: begin
				state_d = ST_SCAN;
				if (rd_free) begin
					x0_d    = cx_q;
					y0_d    = cy_q;
					rw_d    = WW'(1);
					state_d = ST_WID;
				end else if (cx_inc >= eff_w_q) begin
					cx_d = '0;
					if (cy_inc >= eff_h_q) begin
						done_d  = 1'b1;
						cy_d    = '0;
						found_d = 1'b0;
						state_d = ST_EMIT;
					end else begin
						cy_d   = YW'(cy_inc);
						base_d = base_q + LW'(eff_w_q);
					end
				end else begin
					cx_d = XW'(cx_inc);
				end
			end

			ST_WID: begin
				if (WW'(x0_q) + rw_q < eff_w_q) begin
					rd_en   = 1'b1;
					rd_addr = wid_addr;
					state_d = ST_WID_CHK;
				end else begin
					hy_d    = HW'(y0_q) + HW'(1);
					rb_d    = base_q + LW'(eff_w_q);
					rh_d    = HW'(1);
					state_d = ST_HGT_ROW;
				end
			end

			ST_WID_CHK: begin
				if (rd_free) begin
					rw_d    = rw_q + WW'(1);
					state_d = ST_WID;
				end else begin
					hy_d    = HW'(y0_q) + HW'(1);
					rb_d    = base_q + LW'(eff_w_q);
					rh_d    = HW'(1);
					state_d = ST_HGT_ROW;
				end
			end

			ST_HGT_ROW: begin
				if (hy_q >= eff_h_q) begin
					rb_d    = base_q;
					run_d   = '0;
					hy_d    = '0;
					state_d = ST_MERGE;
				end else begin
					run_d   = '0;
					state_d = ST_HGT;
				end
			end

			ST_HGT: begin
				if (run_q < rw_q) begin
					rd_en   = 1'b1;
					rd_addr = hgt_addr;
					state_d = ST_HGT_CHK;
				end else begin
					// whole run free, row joins the rectangle
					rh_d    = rh_q + HW'(1);
					hy_d    = hy_q + HW'(1);
					rb_d    = rb_q + LW'(eff_w_q);
					state_d = ST_HGT_ROW;
				end
			end

			ST_HGT_CHK: begin
				if (rd_free) begin
					run_d   = run_q + WW'(1);
					state_d = ST_HGT;
				end else begin
					rb_d    = base_q;
					run_d   = '0;
					hy_d    = '0;
					state_d = ST_MERGE;
				end
			end

			ST_MERGE: begin
				// mark covered pixels, row by row
				mrg_we  = 1'b1;
				mrg_bit = 1'b1;
				wr_addr = hgt_addr[AW-1:0];
				if (run_q == rw_q - WW'(1)) begin
					run_d = '0;
					if (hy_q == rh_q - HW'(1)) begin
						found_d = 1'b1;
						state_d = ST_EMIT;
						// step the scan past the rectangle
						if (x_end >= eff_w_q) begin
							cx_d = '0;
							if (cy_inc >= eff_h_q) begin
								done_d = 1'b1;
								cy_d   = '0;
							end else begin
								cy_d = YW'(cy_inc);
							end
						end else begin
							cx_d = XW'(x_end);
						end
					end else begin
						hy_d = hy_q + HW'(1);
						rb_d = rb_q + LW'(eff_w_q);
					end
				end else begin
					run_d = run_q + WW'(1);
				end
			end

			ST_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (rsp.ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			load_addr_q <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			clr_busy_q  <= clr_busy_d;
			clr_addr_q  <= clr_addr_d;
			load_addr_q <= load_addr_d;
			cx_q        <= cx_d;
			cy_q        <= cy_d;
			done_q      <= done_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q  <= base_d;
		x0_q    <= x0_d;
		y0_q    <= y0_d;
		rw_q    <= rw_d;
		rh_q    <= rh_d;
		hy_q    <= hy_d;
		rb_q    <= rb_d;
		run_q   <= run_d;
		found_q <= found_d;
		if (load_out) begin
			rsp_found_q <= found_q;
			rsp_x_q     <= found_q ? COORD_W'(x0_q) : '0;
			rsp_y_q     <= found_q ? COORD_W'(y0_q) : '0;
			rsp_w_q     <= found_q ? SIZE_W'(rw_q) : '0;
			rsp_h_q     <= found_q ? SIZE_W'(rh_q) : '0;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.rect_x      = rsp_x_q;
	assign rsp.rect_y      = rsp_y_q;
	assign rsp.rect_width  = rsp_w_q;
	assign rsp.rect_height = rsp_h_q;

	gmrc_store #(
		.DEPTH (STORE),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr[AW-1:0]),
		.rd_free (rd_free),
		.wr_addr (wr_addr),
		.opq_we  (opq_we),
		.opq_bit (opq_bit),
		.mrg_we  (mrg_we),
		.mrg_bit (mrg_bit)
	);

endmodule

@@ tb/sv/cover_check_pkg.sv @@
// scoreboard of the greedy mask rectangle cover testbench: a bit-accurate
// predictor of the load, fetch and clear items and a store of expected rectangles
// depends on gmrc_pkg
`timescale 1ns / 100ps

package cover_check_pkg;
	import gmrc_pkg::*;

	localparam int unsigned MASK_CELLS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [SIZE_W-1:0]  w;
		logic [SIZE_W-1:0]  h;
	} rect_t;

	class cover_scoreboard;
		bit          opaque_px [MASK_CELLS];
		bit          merged_px [MASK_CELLS];
		int unsigned reg_w;
		int unsigned reg_h;
		int unsigned load_ptr;
		int unsigned loaded_limit;  // every mask address below this was loaded
		int unsigned col;
		int unsigned row;
		bit          finished;
		int unsigned effective_items;
		int unsigned errors;
		rect_t       expected_rects [$];

		function new();
			reg_w = CFG_RESET;
			reg_h = CFG_RESET;
			loaded_limit = 0;
			effective_items = 0;
			errors = 0;
			restart_scan();
		endfunction

		function int unsigned span_w();
			if (reg_w == 0) return 1;
			if (reg_w > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return reg_w;
		endfunction

		function int unsigned span_h();
			if (reg_h == 0) return 1;
			if (reg_h > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
			return reg_h;
		endfunction

		// a fetch may only probe loaded pixels
		function bit mask_ready();
			return loaded_limit >= span_w() * span_h();
		endfunction

		function void restart_scan();
			foreach (merged_px[i]) merged_px[i] = 1'b0;
			load_ptr = 0;
			col = 0;
			row = 0;
			finished = 1'b0;
		endfunction

		function bit free_px(int unsigned x, int unsigned y, int unsigned w);
			int unsigned a;
			a = y * w + x;
			if (a >= MASK_CELLS) return 1'b0;
			return opaque_px[a] && !merged_px[a];
		endfunction

		function void step_scan(int unsigned n, int unsigned w, int unsigned h);
			col += n;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) begin
					row = 0;
					finished = 1'b1;
				end
			end
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_WIDTH) reg_w = 32'(value);
			else if (idx == REG_HEIGHT) reg_h = 32'(value);
		endfunction

		// next rectangle of the greedy raster cover, or an all-zero done item
		function rect_t carve_next_rect();
			int unsigned w, h, x0, y0, rw, rh, run, x, y;
			rect_t r;
			w = span_w();
			h = span_h();
			r = '0;
			if (!finished && row >= h) begin
				row = 0;
				col = 0;
				finished = 1'b1;
			end
			while (!finished) begin
				if (col >= w) begin
					step_scan(0, w, h);
				end else if (free_px(col, row, w)) begin
					x0 = col;
					y0 = row;
					rw = 0;
					while (x0 + rw < w && free_px(x0 + rw, y0, w)) rw++;
					rh = 1;
					for (y = y0 + 1; y < h; y++) begin
						run = 0;
						while (run < rw && free_px(x0 + run, y, w)) run++;
						if (run < rw) break;
						rh++;
					end
					for (y = y0; y < y0 + rh; y++)
						for (x = x0; x < x0 + rw; x++)
							if (y * w + x < MASK_CELLS) merged_px[y * w + x] = 1'b1;
					r.found = 1'b1;
					r.x = COORD_W'(x0);
					r.y = COORD_W'(y0);
					r.w = SIZE_W'(rw);
					r.h = SIZE_W'(rh);
					step_scan(rw, w, h);
					return r;
				end else begin
					step_scan(1, w, h);
				end
			end
			return r;
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [ALPHA_W-1:0] alpha);
			case (op)
				OP_LOAD: begin
					if (load_ptr < span_w() * span_h()) begin
						opaque_px[load_ptr] = (alpha != 0);
						load_ptr++;
						if (load_ptr > loaded_limit) loaded_limit = load_ptr;
						effective_items++;
					end
				end
				OP_CLEAR: begin
					restart_scan();
					effective_items++;
				end
				OP_FETCH: begin
					// queue the predicted item at the tail
					expected_rects = {expected_rects, carve_next_rect()};
					effective_items++;
				end
				default: ;
			endcase
		endfunction

		function void compare_field(string field, logic [SIZE_W-1:0] want_v,
				logic [SIZE_W-1:0] got_v);
			if (want_v !== got_v) begin
				$display("%0t: %s expected %0d, actual %0d", $time, field, want_v, got_v);
				errors++;
			end
		endfunction

		function void check_result(rect_t got);
			rect_t want;
			if (expected_rects.size() == 0) begin
				$display("%0t: unexpected item found=%0b x=%0d y=%0d w=%0d h=%0d",
					$time, got.found, got.x, got.y, got.w, got.h);
				errors++;
				return;
			end
			want = expected_rects.pop_front();
			compare_field("found", want.found, got.found);
			compare_field("rect_x", want.x, got.x);
			compare_field("rect_y", want.y, got.y);
			compare_field("rect_width", want.w, got.w);
			compare_field("rect_height", want.h, got.h);
		endfunction
	endclass

endpackage

@@ tb/sv/tb_greedy_mask_rectangle_cover_core.sv @@
// testbench top of greedy_mask_rectangle_cover_core: loads alpha masks, fetches the
// rectangle cover under random stalls and checks each item against the scoreboard
// depends on gmrc_pkg, the gmrc interfaces, cover_check_pkg and the core
`timescale 1ns / 100ps

module tb_greedy_mask_rectangle_cover_core;
	import gmrc_pkg::*;
	import cover_check_pkg::*;

	// codes the package leaves unnamed: the spare operation and spare indexes
	localparam logic [OP_W-1:0]      OP_SPARE    = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	localparam int ITEM_GOAL  = 1550;
	localparam int MAX_PHASES = 10;       // every phase costs a full clearing pass
	localparam int SETTLE     = 32;       // cycles after the last item before a write
	localparam int IDLE_PCT   = 36;
	localparam int LIMIT_NS   = 60_000_000;

	logic clk;
	logic arst_n;
	logic take_ready = 1'b0;
	bit   steady = 1'b0;                  // no idling on either side while set

	// 3x2 mask of the directed part: opaque on the right of row 0, all of row 1
	logic [ALPHA_W-1:0] corner_alpha [6] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'hFF, 8'h7F};

	cover_scoreboard book = new();

	gmrc_req_if req();
	gmrc_rsp_if rsp();
	gmrc_cfg_if cfg();

	assign rsp.ready = take_ready;

	greedy_mask_rectangle_cover_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop, several times the slowest legal run including all clearing passes
	initial begin
		#(LIMIT_NS);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: check on every accepted item, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			book.check_result({rsp.found, rsp.rect_x, rsp.rect_y, rsp.rect_width,
				rsp.rect_height});
		take_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// opaque with the given percentage; opaque alphas cover 1..255
	function automatic logic [ALPHA_W-1:0] pixel_alpha(int unsigned density);
		if ($urandom_range(99) < density) return 8'($urandom_range(1, 255));
		return '0;
	endfunction

	// one request item; valid stays high after acceptance so items can stream
	task automatic send_request(logic [OP_W-1:0] op, logic [ALPHA_W-1:0] alpha);
		if (!steady)
			while ($urandom_range(99) < IDLE_PCT) begin
				req.valid <= 1'b0;
				@(posedge clk);
			end
		req.valid <= 1'b1;
		req.operation <= op;
		req.alpha <= alpha;
		do @(posedge clk); while (!req.ready);
		book.note_request(op, alpha);
	endtask

	// leaves cfg.valid high; the caller drops it after the last write of a batch
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		book.set_register(idx, value);
	endtask

	// stop sending until every fetch has answered, then let loads settle
	task automatic wait_drained();
		req.valid <= 1'b0;
		while (book.expected_rects.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// unused operation code as noise, ignored by the block
	task automatic sprinkle_spare(int unsigned pct);
		if ($urandom_range(99) < pct) send_request(OP_SPARE, 8'($urandom));
	endtask

	// one image: size the mask, clear, load it, fetch the whole cover
	task automatic run_phase(int ph);
		int unsigned wraw, hraw, wh, loads, density, countdown;
		bit reshape;
		wait_drained();
		steady = (ph == 1);
		case (ph)
			0: begin
				// widest row: a fully opaque line gives one 256-wide rectangle
				wraw = 256;
				hraw = 1;
				density = 100;
			end
			1: begin
				// tallest column, also the stretch with no idling
				wraw = 1;
				hraw = 256;
				density = 100;
			end
			2: begin
				// out of range: width 0 acts as 1, height 511 as the maximum
				wraw = 0;
				hraw = 511;
				density = 70;
			end
			default: begin
				wraw = $urandom_range(2, 20);
				hraw = $urandom_range(2, 20);
				density = (ph == 3) ? 50 : 25 * $urandom_range(4);
			end
		endcase
		write_register(REG_WIDTH, 9'(wraw));
		write_register(REG_HEIGHT, 9'(hraw));
		cfg.valid <= 1'b0;
		send_request(OP_CLEAR, 8'($urandom));

		// the mask outlives a clear, so a partial reload is legal once loaded
		wh = book.span_w() * book.span_h();
		loads = wh;
		if (book.mask_ready() && $urandom_range(3) == 0) loads = $urandom_range(0, wh);
		repeat (loads) begin
			sprinkle_spare(3);
			send_request(OP_LOAD, pixel_alpha(density));
		end
		// loads past the end of the image are dropped
		repeat ($urandom_range(0, 2)) send_request(OP_LOAD, pixel_alpha(density));

		// fetch until the done item, now and then resizing the image mid scan
		reshape = (ph == 3) || (ph > 3 && $urandom_range(1) == 1);
		countdown = $urandom_range(1, 6);
		while (!book.finished) begin
			sprinkle_spare(5);
			if ($urandom_range(99) < 6) send_request(OP_LOAD, pixel_alpha(density));
			send_request(OP_FETCH, 8'($urandom));
			if (reshape) begin
				countdown--;
				if (countdown == 0) begin
					reshape = 1'b0;
					// scan position may now lie outside the image and wrap or finish
					wait_drained();
					if ($urandom_range(1)) write_register(REG_WIDTH, 9'($urandom_range(1, 20)));
					else write_register(REG_HEIGHT, 9'($urandom_range(1, 20)));
					cfg.valid <= 1'b0;
					// a larger image needs its new pixels loaded before any fetch
					while (!book.mask_ready()) send_request(OP_LOAD, pixel_alpha(density));
				end
			end
		end
		// fetches after the scan finished return found = 0
		repeat ($urandom_range(1, 2)) send_request(OP_FETCH, 8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_LOAD;
		req.alpha = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_WIDTH;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: a 3x2 mask with a 2x2 and a 1x1 rectangle, spare indexes too
		write_register(REG_WIDTH, 9'd3);
		write_register(REG_HEIGHT, 9'd2);
		write_register(REG_SPARE_2, 9'($urandom));
		write_register(REG_SPARE_3, 9'h1FF);
		cfg.valid <= 1'b0;
		foreach (corner_alpha[i]) send_request(OP_LOAD, corner_alpha[i]);
		send_request(OP_LOAD, 8'hFF);           // past the end, dropped
		send_request(OP_SPARE, 8'h55);
		repeat (4) send_request(OP_FETCH, 8'hAA); // two rectangles, done, done again
		// clear keeps the opaque mask: the same cover comes back without loads
		send_request(OP_CLEAR, 8'h00);
		repeat (3) send_request(OP_FETCH, 8'h00);

		for (int ph = 0; ph < MAX_PHASES && book.effective_items < ITEM_GOAL; ph++)
			run_phase(ph);

		wait_drained();
		if (book.errors == 0 && book.expected_rects.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/gmrc_pkg.sv
sv/gmrc_req_if.sv
sv/gmrc_rsp_if.sv
sv/gmrc_cfg_if.sv
sv/gmrc_store.sv
sv/greedy_mask_rectangle_cover_core.sv
tb/sv/cover_check_pkg.sv
tb/sv/tb_greedy_mask_rectangle_cover_core.sv
